// File: rtl/fmsr_pkg.sv
// Shared constants, codes, control structs and helpers of the substring rule table.
package fmsr_pkg;

  localparam int unsigned MaxRulesDef     = 96;
  localparam int unsigned PatternBytesDef = 48;

  // Widths fixed by the word fields.
  localparam int unsigned OpW       = 2;
  localparam int unsigned RuleIdxW  = 7;
  localparam int unsigned PosW      = 6;
  localparam int unsigned CharW     = 8;
  localparam int unsigned PlenW     = 6;
  localparam int unsigned AspectW   = 16;
  localparam int unsigned RuleCntW  = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [OpW-1:0] OpPatByte  = 2'd0;
  localparam logic [OpW-1:0] OpRuleWr   = 2'd1;
  localparam logic [OpW-1:0] OpNameChar = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgRuleCount    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDefaultAspect = 2'd1;

  typedef struct packed {
    logic capture;
    logic pat_rd;
    logic pat_wr;
    logic rule_wr;
    logic scan_start;
    logic scan_rd;
    logic lookup_rd;
    logic result_ld;
  } cmd_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic           item_ok;
    logic           char_valid;
    logic           last;
    logic           scan_last;
    logic           out_busy;
  } status_t;

  function automatic logic [CharW-1:0] fold_case(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) r = c + 8'h20;
    return r;
  endfunction

endpackage

// File: rtl/fmsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fmsr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/fmsr_ctrl.sv
// Sequencer of the substring rule table: decodes words and steps the rule scan.
module fmsr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fmsr_pkg::status_t status_i,
  output fmsr_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_PAT_RD, S_PAT_WR, S_SCAN, S_DRAIN, S_LOOKUP, S_RESULT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_IDLE;
        case (status_i.op)
          fmsr_pkg::OpPatByte: begin
            if (status_i.item_ok) state_d = S_PAT_RD;
          end
          fmsr_pkg::OpRuleWr: begin
            cmd_o.rule_wr = status_i.item_ok;
          end
          fmsr_pkg::OpNameChar: begin
            if (status_i.char_valid) begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_SCAN;
            end else if (status_i.last) begin
              state_d = S_LOOKUP;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_PAT_RD: begin
        cmd_o.pat_rd = 1'b1;
        state_d      = S_PAT_WR;
      end
      S_PAT_WR: begin
        cmd_o.pat_wr = 1'b1;
        state_d      = S_IDLE;
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (status_i.scan_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        state_d = status_i.last ? S_LOOKUP : S_IDLE;
      end
      S_LOOKUP: begin
        cmd_o.lookup_rd = 1'b1;
        state_d         = S_RESULT;
      end
      S_RESULT: begin
        if (!status_i.out_busy) begin
          cmd_o.result_ld = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/fmsr_dpath.sv
// Datapath of the substring rule table: rule memories, match step and result register.
module fmsr_dpath #(
  parameter int unsigned RULE_SLOTS    = fmsr_pkg::MaxRulesDef,
  parameter int unsigned PATTERN_BYTES = fmsr_pkg::PatternBytesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fmsr_pkg::cmd_t                  cmd_i,
  output fmsr_pkg::status_t               status_o,
  input  logic [fmsr_pkg::OpW-1:0]        operation_i,
  input  logic [fmsr_pkg::RuleIdxW-1:0]   rule_index_i,
  input  logic [fmsr_pkg::PosW-1:0]       char_pos_i,
  input  logic [fmsr_pkg::CharW-1:0]      char_value_i,
  input  logic [fmsr_pkg::PlenW-1:0]      pattern_length_i,
  input  logic [fmsr_pkg::AspectW-1:0]    aspect_value_i,
  input  logic                            name_last_i,
  input  logic                            name_char_valid_i,
  input  logic                            cfg_valid_i,
  input  logic [fmsr_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [fmsr_pkg::CfgDataW-1:0]   cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            matched_o,
  output logic [fmsr_pkg::RuleIdxW-1:0]   matched_rule_o,
  output logic [fmsr_pkg::AspectW-1:0]    aspect_o,
  output logic                            override_o
);

  localparam int unsigned PatMax = PATTERN_BYTES - 1;
  localparam int unsigned RowW   = PatMax * fmsr_pkg::CharW;
  localparam int unsigned LenW   = $clog2(PatMax + 1);
  localparam int unsigned IdxW   = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int unsigned CntW   = $clog2(RULE_SLOTS + 1);
  localparam int unsigned RuleW  = LenW + fmsr_pkg::AspectW;

  // Captured word.
  logic [fmsr_pkg::OpW-1:0]      op_q;
  logic [fmsr_pkg::RuleIdxW-1:0] idx_q;
  logic [fmsr_pkg::PosW-1:0]     pos_q;
  logic [fmsr_pkg::CharW-1:0]    ch_q;
  logic [fmsr_pkg::PlenW-1:0]    plen_q;
  logic [fmsr_pkg::AspectW-1:0]  asp_q;
  logic                          last_q;
  logic                          cvalid_q;

  logic [fmsr_pkg::RuleCntW-1:0] rules_used_q;
  logic [fmsr_pkg::AspectW-1:0]  fallback_asp_q;
  logic [RULE_SLOTS-1:0]         rule_vld_q;
  logic [RULE_SLOTS-1:0]         prog_vld_q;
  logic                          rule_rd_vld_q;
  logic                          prog_rd_vld_q;
  logic [CntW-1:0]               cnt_q;
  logic [CntW-1:0]               first_hit_q;
  logic                          seen_q;
  logic                          s1_valid_q;
  logic [IdxW-1:0]               s1_addr_q;

  logic                          out_valid_q;
  logic                          matched_q;
  logic [fmsr_pkg::RuleIdxW-1:0] matched_rule_q;
  logic [fmsr_pkg::AspectW-1:0]  aspect_q;

  logic [IdxW-1:0] cap_addr, cnt_addr, hit_addr, rule_raddr, pat_raddr;
  logic [RowW-1:0] pat_rdata, pat_wdata;
  logic [RuleW-1:0] rule_rdata, rule_wdata;
  logic [PatMax-1:0] prog_rdata, prog_d, eq;
  logic [LenW-1:0] len_rd, len_sat;
  logic [fmsr_pkg::AspectW-1:0] asp_rd;
  logic [PatMax-1:0] prog_rd;
  logic [fmsr_pkg::CharW-1:0] fc;
  logic row_hit;
  logic idx_ok, pos_ok;
  logic [fmsr_pkg::RuleCntW-1:0] rc_lim;
  logic hit;
  logic [fmsr_pkg::AspectW-1:0] asp_sel;

  assign cap_addr   = idx_q[IdxW-1:0];
  assign cnt_addr   = cnt_q[IdxW-1:0];
  assign hit_addr   = first_hit_q[IdxW-1:0];
  assign pat_raddr  = cmd_i.scan_rd ? cnt_addr : cap_addr;
  assign rule_raddr = cmd_i.scan_rd ? cnt_addr : hit_addr;

  assign idx_ok = 32'(idx_q) < RULE_SLOTS;
  assign pos_ok = 32'(pos_q) < PatMax;

  always_comb begin
    if (32'(plen_q) > PatMax) len_sat = LenW'(PatMax);
    else                      len_sat = plen_q[LenW-1:0];
  end

  // Byte merge for a pattern write.
  always_comb begin
    for (int j = 0; j < PatMax; j++) begin
      if (32'(pos_q) == j) pat_wdata[j*8 +: 8] = ch_q;
      else                 pat_wdata[j*8 +: 8] = pat_rdata[j*8 +: 8];
    end
  end

  assign rule_wdata = {len_sat, asp_q};

  fmsr_ram #(.WIDTH(RowW), .DEPTH(RULE_SLOTS)) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.pat_wr),
    .waddr_i (cap_addr),
    .wdata_i (pat_wdata),
    .re_i    (cmd_i.pat_rd | cmd_i.scan_rd),
    .raddr_i (pat_raddr),
    .rdata_o (pat_rdata)
  );

  fmsr_ram #(.WIDTH(RuleW), .DEPTH(RULE_SLOTS)) u_rule_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.rule_wr),
    .waddr_i (cap_addr),
    .wdata_i (rule_wdata),
    .re_i    (cmd_i.scan_rd | cmd_i.lookup_rd),
    .raddr_i (rule_raddr),
    .rdata_o (rule_rdata)
  );

  fmsr_ram #(.WIDTH(PatMax), .DEPTH(RULE_SLOTS)) u_prog_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (prog_d),
    .re_i    (cmd_i.scan_rd),
    .raddr_i (cnt_addr),
    .rdata_o (prog_rdata)
  );

  // Match step for one rule row; rule and progress entries never written read as zero.
  assign len_rd  = rule_rd_vld_q ? rule_rdata[RuleW-1 -: LenW] : '0;
  assign asp_rd  = rule_rd_vld_q ? rule_rdata[fmsr_pkg::AspectW-1:0] : '0;
  assign prog_rd = prog_rd_vld_q ? prog_rdata : '0;
  assign fc      = fmsr_pkg::fold_case(ch_q);

  always_comb begin
    for (int j = 0; j < PatMax; j++) begin
      eq[j] = (fmsr_pkg::fold_case(pat_rdata[j*8 +: 8]) == fc) && (j < 32'(len_rd));
    end
  end

  assign prog_d = ((prog_rd << 1) | PatMax'(1)) & eq;

  always_comb begin
    row_hit = 1'b0;
    for (int j = 0; j < PatMax; j++) begin
      if (32'(len_rd) == j + 1) row_hit = prog_d[j];
    end
  end

  assign rc_lim  = (32'(rules_used_q) > RULE_SLOTS) ? fmsr_pkg::RuleCntW'(RULE_SLOTS)
                                                    : rules_used_q;
  assign hit     = seen_q && (32'(first_hit_q) < 32'(rc_lim));
  assign asp_sel = hit ? asp_rd : fallback_asp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= operation_i;
      idx_q    <= rule_index_i;
      pos_q    <= char_pos_i;
      ch_q     <= char_value_i;
      plen_q   <= pattern_length_i;
      asp_q    <= aspect_value_i;
      last_q   <= name_last_i;
      cvalid_q <= name_char_valid_i;
    end
    if (cmd_i.scan_rd) begin
      s1_addr_q <= cnt_addr;
    end
    if (cmd_i.result_ld) begin
      matched_q      <= hit;
      matched_rule_q <= hit ? fmsr_pkg::RuleIdxW'(first_hit_q) : '0;
      aspect_q       <= asp_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rules_used_q     <= '0;
      fallback_asp_q   <= '0;
      rule_vld_q       <= '0;
      prog_vld_q       <= '0;
      rule_rd_vld_q    <= 1'b0;
      prog_rd_vld_q    <= 1'b0;
      cnt_q            <= '0;
      first_hit_q      <= CntW'(RULE_SLOTS);
      seen_q           <= 1'b0;
      s1_valid_q       <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.scan_rd;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          fmsr_pkg::CfgRuleCount:
            rules_used_q <= fmsr_pkg::RuleCntW'(cfg_data_i[fmsr_pkg::RuleIdxW-1:0]);
          fmsr_pkg::CfgDefaultAspect: fallback_asp_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.rule_wr) begin
        rule_vld_q[cap_addr] <= 1'b1;
        prog_vld_q[cap_addr] <= 1'b0;
        if (fmsr_pkg::RuleCntW'(idx_q) >= rules_used_q) begin
          rules_used_q <= fmsr_pkg::RuleCntW'(idx_q) + 1'b1;
        end
      end
      if (cmd_i.scan_start) begin
        cnt_q  <= '0;
        seen_q <= 1'b1;
      end
      if (cmd_i.scan_rd) begin
        cnt_q         <= cnt_q + 1'b1;
        rule_rd_vld_q <= rule_vld_q[cnt_addr];
        prog_rd_vld_q <= prog_vld_q[cnt_addr];
      end
      if (cmd_i.lookup_rd) begin
        rule_rd_vld_q <= rule_vld_q[hit_addr];
      end
      if (s1_valid_q) begin
        prog_vld_q[s1_addr_q] <= 1'b1;
        if (row_hit && (CntW'(s1_addr_q) < first_hit_q)) begin
          first_hit_q <= CntW'(s1_addr_q);
        end
      end
      if (cmd_i.result_ld) begin
        out_valid_q <= 1'b1;
        prog_vld_q  <= '0;
        first_hit_q <= CntW'(RULE_SLOTS);
        seen_q      <= 1'b0;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.op         = op_q;
  assign status_o.item_ok    = idx_ok && ((op_q != fmsr_pkg::OpPatByte) || pos_ok);
  assign status_o.char_valid = cvalid_q;
  assign status_o.last       = last_q;
  assign status_o.scan_last  = (cnt_q == CntW'(RULE_SLOTS - 1));
  assign status_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign matched_o      = matched_q;
  assign matched_rule_o = matched_rule_q;
  assign aspect_o       = aspect_q;
  assign override_o     = (aspect_q != '0);

endmodule

// File: rtl/first_match_substring_rule_table.sv
// Top level of the first-match substring rule table.
//
// Usage: rule words (operation 0 writes one pattern byte, operation 1 writes a
// rule's length and aspect) fill the table; then a name streams in as
// operation 2 words, one character each, the final word marked by name_last.
// Matching folds ASCII A-Z to lower case on both sides and keeps the lowest
// matching rule. The final word of a name yields one result word: the first
// matching rule and its aspect, or the fallback aspect when nothing matched.
// Channels: input and result use valid/ready; the config port (index 0
// number of rules in use, index 1 fallback aspect) is always ready. The user
// must see that it is written only while the block is idle; the block itself
// does not enforce this.
// Steps: a pattern byte is accepted, decoded, its row read, then merged and
// written back; a rule write is accepted and decoded; a name character starts
// a scan that reads one rule row per cycle from the pattern, rule and progress
// memories, then drains. A final word adds an aspect lookup and a result load.
// Reset: clears all rules to disabled through per-rule valid bits, zeroes both
// config registers; pattern bytes stay undefined until written.
// Stall: the result sits in an output register; new words are still taken
// while it waits, and only the next result load holds until it drains.
module first_match_substring_rule_table #(
  parameter int unsigned RULE_SLOTS    = fmsr_pkg::MaxRulesDef,
  parameter int unsigned PATTERN_BYTES = fmsr_pkg::PatternBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [fmsr_pkg::OpW-1:0]      operation_i,
  input  logic [fmsr_pkg::RuleIdxW-1:0] rule_index_i,
  input  logic [fmsr_pkg::PosW-1:0]     char_pos_i,
  input  logic [fmsr_pkg::CharW-1:0]    char_value_i,
  input  logic [fmsr_pkg::PlenW-1:0]    pattern_length_i,
  input  logic [fmsr_pkg::AspectW-1:0]  aspect_value_i,
  input  logic                          name_last_i,
  input  logic                          name_char_valid_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          matched_o,
  output logic [fmsr_pkg::RuleIdxW-1:0] matched_rule_o,
  output logic [fmsr_pkg::AspectW-1:0]  aspect_o,
  output logic                          override_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fmsr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fmsr_pkg::CfgDataW-1:0] cfg_data_i
);

  fmsr_pkg::cmd_t    cmd;
  fmsr_pkg::status_t status;

  // Config writes land directly in the datapath registers.
  assign cfg_ready_o = 1'b1;

  fmsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fmsr_dpath #(
    .RULE_SLOTS    (RULE_SLOTS),
    .PATTERN_BYTES (PATTERN_BYTES)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .operation_i       (operation_i),
    .rule_index_i      (rule_index_i),
    .char_pos_i        (char_pos_i),
    .char_value_i      (char_value_i),
    .pattern_length_i  (pattern_length_i),
    .aspect_value_i    (aspect_value_i),
    .name_last_i       (name_last_i),
    .name_char_valid_i (name_char_valid_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .matched_o         (matched_o),
    .matched_rule_o    (matched_rule_o),
    .aspect_o          (aspect_o),
    .override_o        (override_o)
  );

endmodule

// File: dv/fmsr_checker.sv
// Checker for the substring rule table: predicts result words and compares them.
`timescale 1ns / 100ps

module fmsr_checker #(
  parameter int unsigned RULE_SLOTS    = fmsr_pkg::MaxRulesDef,
  parameter int unsigned PATTERN_BYTES = fmsr_pkg::PatternBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [fmsr_pkg::OpW-1:0]      operation_i,
  input  logic [fmsr_pkg::RuleIdxW-1:0] rule_index_i,
  input  logic [fmsr_pkg::PosW-1:0]     char_pos_i,
  input  logic [fmsr_pkg::CharW-1:0]    char_value_i,
  input  logic [fmsr_pkg::PlenW-1:0]    pattern_length_i,
  input  logic [fmsr_pkg::AspectW-1:0]  aspect_value_i,
  input  logic                          name_last_i,
  input  logic                          name_char_valid_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic                          matched_i,
  input  logic [fmsr_pkg::RuleIdxW-1:0] matched_rule_i,
  input  logic [fmsr_pkg::AspectW-1:0]  aspect_i,
  input  logic                          override_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [fmsr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fmsr_pkg::CfgDataW-1:0] cfg_data_i,
  output int unsigned                   pending_o,
  output int unsigned                   errors_o
);

  localparam int unsigned PatMax = PATTERN_BYTES - 1;

  typedef struct packed {
    logic                          matched;
    logic [fmsr_pkg::RuleIdxW-1:0] rule;
    logic [fmsr_pkg::AspectW-1:0]  aspect;
    logic                          override;
  } pick_t;

  logic [fmsr_pkg::CharW-1:0]    pat_bytes [RULE_SLOTS][PatMax];
  logic [fmsr_pkg::PlenW-1:0]    pat_len   [RULE_SLOTS];
  logic [fmsr_pkg::AspectW-1:0]  rule_asp  [RULE_SLOTS];
  logic [PatMax-1:0]             progress  [RULE_SLOTS];
  int unsigned                   first_hit;
  logic                          char_seen;
  logic [fmsr_pkg::RuleIdxW-1:0] rules_used;
  logic [fmsr_pkg::AspectW-1:0]  dflt_aspect;
  pick_t                         pending_picks [$];

  assign pending_o = pending_picks.size();

  function automatic logic [fmsr_pkg::CharW-1:0] to_lower(
    input logic [fmsr_pkg::CharW-1:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  // Advance every enabled rule's shift-and progress by one name byte.
  task automatic scan_char(input logic [fmsr_pkg::CharW-1:0] c);
    logic [PatMax-1:0] eq;
    logic [PatMax-1:0] d;
    for (int r = 0; r < RULE_SLOTS; r++) begin
      if (pat_len[r] != 0) begin
        eq = '0;
        for (int j = 0; j < pat_len[r]; j++)
          if (to_lower(pat_bytes[r][j]) == to_lower(c)) eq[j] = 1'b1;
        d = ((progress[r] << 1) | PatMax'(1)) & eq;
        progress[r] = d;
        if (d[pat_len[r]-1] && r < first_hit) first_hit = r;
      end
    end
  endtask

  task automatic clear_name();
    for (int r = 0; r < RULE_SLOTS; r++) progress[r] = '0;
    first_hit = RULE_SLOTS;
    char_seen = 1'b0;
  endtask

  task automatic apply_word();
    int unsigned limit;
    pick_t       p;
    case (operation_i)
      fmsr_pkg::OpPatByte: begin
        if (rule_index_i < RULE_SLOTS && char_pos_i < PatMax)
          pat_bytes[rule_index_i][char_pos_i] = char_value_i;
      end
      fmsr_pkg::OpRuleWr: begin
        if (rule_index_i < RULE_SLOTS) begin
          pat_len[rule_index_i]  = (pattern_length_i > PatMax)
                                   ? fmsr_pkg::PlenW'(PatMax) : pattern_length_i;
          rule_asp[rule_index_i] = aspect_value_i;
          progress[rule_index_i] = '0;
          if (rule_index_i >= rules_used)
            rules_used = fmsr_pkg::RuleIdxW'(rule_index_i + 1);
        end
      end
      fmsr_pkg::OpNameChar: begin
        if (name_char_valid_i) begin
          scan_char(char_value_i);
          char_seen = 1'b1;
        end
        if (name_last_i) begin
          limit      = (rules_used > RULE_SLOTS) ? RULE_SLOTS : rules_used;
          p.matched  = char_seen && first_hit < limit;
          p.rule     = p.matched ? fmsr_pkg::RuleIdxW'(first_hit) : '0;
          p.aspect   = p.matched ? rule_asp[first_hit] : dflt_aspect;
          p.override = p.aspect != 0;
          pending_picks.push_back(p);
          clear_name();
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_word();
    pick_t e;
    pick_t a;
    a = '{matched_i, matched_rule_i, aspect_i, override_i};
    if (pending_picks.size() == 0) begin
      $display("%0t: unexpected result word %p", $time, a);
      errors_o++;
    end else begin
      e = pending_picks.pop_front();
      if (a.matched != e.matched) begin
        $display("%0t: matched exp %0d got %0d", $time, e.matched, a.matched);
        errors_o++;
      end
      if (a.rule != e.rule) begin
        $display("%0t: matched_rule exp %0d got %0d", $time, e.rule, a.rule);
        errors_o++;
      end
      if (a.aspect != e.aspect) begin
        $display("%0t: aspect exp %h got %h", $time, e.aspect, a.aspect);
        errors_o++;
      end
      if (a.override != e.override) begin
        $display("%0t: override exp %0d got %0d", $time, e.override, a.override);
        errors_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < RULE_SLOTS; r++) begin
        pat_len[r]  = '0;
        rule_asp[r] = '0;
        for (int j = 0; j < PatMax; j++) pat_bytes[r][j] = '0;
      end
      clear_name();
      rules_used  = '0;
      dflt_aspect = '0;
      pending_picks.delete();
      errors_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_word();
      if (in_valid_i && in_ready_i) apply_word();
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == fmsr_pkg::CfgRuleCount)
          rules_used = cfg_data_i[fmsr_pkg::RuleIdxW-1:0];
        else if (cfg_index_i == fmsr_pkg::CfgDefaultAspect)
          dflt_aspect = cfg_data_i;
      end
    end
  end

endmodule

// File: dv/tb_first_match_substring_rule_table.sv
// Testbench top for the substring rule table: stimulus, idling and verdict.
`timescale 1ns / 100ps

module tb_first_match_substring_rule_table;

  localparam int unsigned NumRules   = fmsr_pkg::MaxRulesDef;
  localparam int unsigned PatMax     = fmsr_pkg::PatternBytesDef - 1;
  localparam logic [fmsr_pkg::OpW-1:0] OpSpare = 2'd3;  // unused code, must be ignored
  localparam int unsigned DrainWait  = NumRules + 16;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned NumWords   = 1800;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [fmsr_pkg::OpW-1:0]      op;
  logic [fmsr_pkg::RuleIdxW-1:0] rule_idx;
  logic [fmsr_pkg::PosW-1:0]     pos;
  logic [fmsr_pkg::CharW-1:0]    chr;
  logic [fmsr_pkg::PlenW-1:0]    plen;
  logic [fmsr_pkg::AspectW-1:0]  asp;
  logic                          last;
  logic                          cvalid;
  logic                          out_valid;
  logic                          out_ready;
  logic                          matched;
  logic [fmsr_pkg::RuleIdxW-1:0] matched_rule;
  logic [fmsr_pkg::AspectW-1:0]  aspect;
  logic                          override;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [fmsr_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [fmsr_pkg::CfgDataW-1:0] cfg_data;
  int unsigned                   pending;
  int unsigned                   errors;
  int unsigned                   words_sent;
  int unsigned                   quiet_cycles;
  logic                          idling_on;
  // Which pattern bytes have been written: rule lengths never reach past them.
  logic [PatMax-1:0]             written [NumRules];

  first_match_substring_rule_table uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .operation_i(op), .rule_index_i(rule_idx), .char_pos_i(pos),
    .char_value_i(chr), .pattern_length_i(plen), .aspect_value_i(asp),
    .name_last_i(last), .name_char_valid_i(cvalid),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .matched_o(matched), .matched_rule_o(matched_rule),
    .aspect_o(aspect), .override_o(override),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  fmsr_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .operation_i(op), .rule_index_i(rule_idx), .char_pos_i(pos),
    .char_value_i(chr), .pattern_length_i(plen), .aspect_value_i(asp),
    .name_last_i(last), .name_char_valid_i(cvalid),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .matched_i(matched), .matched_rule_i(matched_rule),
    .aspect_i(aspect), .override_i(override),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_idx), .cfg_data_i(cfg_data),
    .pending_o(pending), .errors_o(errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: stall at random unless the no-idle stretch is running.
  always @(negedge clk) begin
    out_ready <= idling_on ? ($urandom_range(99) >= 27) : 1'b1;
  end

  // Watchdog: end the run if nothing moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Send one word; optionally hold valid low for random idle cycles first.
  task automatic send_word(input logic [fmsr_pkg::OpW-1:0] o, input int unsigned r,
                           input int unsigned p, input logic [fmsr_pkg::CharW-1:0] c,
                           input int unsigned l, input logic [fmsr_pkg::AspectW-1:0] a,
                           input logic lst, input logic cv);
    while (idling_on && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    rule_idx <= fmsr_pkg::RuleIdxW'(r);
    pos      <= fmsr_pkg::PosW'(p);
    chr      <= c;
    plen     <= fmsr_pkg::PlenW'(l);
    asp      <= a;
    last     <= lst;
    cvalid   <= cv;
    if (o == fmsr_pkg::OpPatByte && r < NumRules && p < PatMax) written[r][p] = 1'b1;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic write_cfg(input logic [fmsr_pkg::CfgIdxW-1:0] i,
                           input logic [fmsr_pkg::CfgDataW-1:0] d);
    cfg_valid <= 1'b1;
    cfg_idx   <= i;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid and wait until every expected result has drained, then let the
  // last scan settle before touching configuration.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DrainWait) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic int unsigned written_prefix(input int unsigned r);
    int unsigned n;
    n = 0;
    while (n < PatMax && written[r][n]) n++;
    return n;
  endfunction

  // Small alphabet with case mixing so that names hit patterns often.
  function automatic logic [fmsr_pkg::CharW-1:0] pick_char();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 10) return fmsr_pkg::CharW'($urandom);
    case ($urandom_range(4))
      0: return "a";
      1: return "A";
      2: return "b";
      3: return "B";
      default: return "c";
    endcase
  endfunction

  task automatic send_rule(input int unsigned r, input int unsigned l,
                           input logic [fmsr_pkg::AspectW-1:0] a);
    for (int j = 0; j < l && j < PatMax; j++)
      send_word(fmsr_pkg::OpPatByte, r, j, pick_char(), 0, '0, 1'b0, 1'b0);
    send_word(fmsr_pkg::OpRuleWr, r, 0, fmsr_pkg::CharW'($urandom), l, a, 1'b0, 1'b0);
  endtask

  task automatic send_name(input int unsigned n);
    for (int j = 0; j < n; j++) begin
      if ($urandom_range(9) == 0)
        send_word(fmsr_pkg::OpNameChar, $urandom_range(127), $urandom_range(63),
                  fmsr_pkg::CharW'($urandom), $urandom_range(63),
                  fmsr_pkg::AspectW'($urandom), 1'b0, 1'b0);
      send_word(fmsr_pkg::OpNameChar, $urandom_range(127), $urandom_range(63),
                pick_char(), $urandom_range(63), fmsr_pkg::AspectW'($urandom),
                1'b0, 1'b1);
    end
    send_word(fmsr_pkg::OpNameChar, $urandom_range(127), $urandom_range(63), pick_char(),
              $urandom_range(63), fmsr_pkg::AspectW'($urandom), 1'b1,
              1'($urandom_range(1)));
  endtask

  task automatic random_phase(input int unsigned count);
    int unsigned stop;
    int unsigned k;
    int unsigned r;
    int unsigned pre;
    stop = words_sent + count;
    while (words_sent < stop) begin
      k = $urandom_range(99);
      if (k < 18) begin
        // Well-formed rule: bytes then length, mostly short patterns.
        r = ($urandom_range(3) == 0) ? $urandom_range(NumRules - 1) : $urandom_range(7);
        k = $urandom_range(19);
        send_rule(r, (k == 0) ? PatMax : (k == 1) ? 0 : $urandom_range(1, 4),
                  ($urandom_range(7) == 0) ? '0 : fmsr_pkg::AspectW'($urandom));
      end else if (k < 88) begin
        send_name($urandom_range(0, 8));
      end else begin
        // Noise: stray writes, out-of-range indexes, spare opcode.
        r   = $urandom_range(127);
        pre = (r < NumRules) ? written_prefix(r) : 63;
        case ($urandom_range(2))
          0: send_word(fmsr_pkg::OpPatByte, r, $urandom_range(63),
                       fmsr_pkg::CharW'($urandom), $urandom_range(63),
                       fmsr_pkg::AspectW'($urandom), 1'($urandom_range(1)),
                       1'($urandom_range(1)));
          1: send_word(fmsr_pkg::OpRuleWr, r, $urandom_range(63),
                       fmsr_pkg::CharW'($urandom),
                       (pre >= PatMax) ? $urandom_range(63) : $urandom_range(pre),
                       fmsr_pkg::AspectW'($urandom), 1'($urandom_range(1)),
                       1'($urandom_range(1)));
          default: send_word(OpSpare, r, $urandom_range(63), fmsr_pkg::CharW'($urandom),
                             $urandom_range(63), fmsr_pkg::AspectW'($urandom),
                             1'($urandom_range(1)), 1'($urandom_range(1)));
        endcase
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    op           = fmsr_pkg::OpPatByte;
    rule_idx     = '0;
    pos          = '0;
    chr          = '0;
    plen         = '0;
    asp          = '0;
    last         = 1'b0;
    cvalid       = 1'b0;
    out_ready    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_idx      = fmsr_pkg::CfgRuleCount;
    cfg_data     = '0;
    words_sent   = 0;
    quiet_cycles = 0;
    idling_on    = 1'b1;
    for (int r = 0; r < NumRules; r++) written[r] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty names and ignored words on a blank table.
    send_word(fmsr_pkg::OpNameChar, 0, 0, 8'h00, 0, '0, 1'b1, 1'b0);
    send_word(fmsr_pkg::OpNameChar, 0, 0, "x", 0, '0, 1'b0, 1'b0);
    send_word(OpSpare, 5, 3, "a", 2, 16'hFFFF, 1'b1, 1'b1);
    send_word(fmsr_pkg::OpPatByte, 127, 0, "z", 0, '0, 1'b0, 1'b0);
    send_word(fmsr_pkg::OpPatByte, 0, PatMax, "z", 0, '0, 1'b0, 1'b0);
    send_word(fmsr_pkg::OpPatByte, 0, 63, "z", 0, '0, 1'b0, 1'b0);
    send_word(fmsr_pkg::OpRuleWr, 96, 0, 8'h00, 5, 16'h1234, 1'b0, 1'b0);
    send_word(fmsr_pkg::OpRuleWr, 127, 0, 8'h00, 5, 16'h1234, 1'b0, 1'b0);
    // Rule 3 "aB" max aspect, rule 95 "\x00\xFF"; rule write extends the table.
    send_word(fmsr_pkg::OpPatByte, 3, 0, "a", 0, '0, 1'b0, 1'b0);
    send_word(fmsr_pkg::OpPatByte, 3, 1, "B", 0, '0, 1'b0, 1'b0);
    send_word(fmsr_pkg::OpRuleWr, 3, 0, 8'h00, 2, 16'hFFFF, 1'b0, 1'b0);
    send_word(fmsr_pkg::OpPatByte, 95, 0, 8'h00, 0, '0, 1'b0, 1'b0);
    send_word(fmsr_pkg::OpPatByte, 95, 1, 8'hFF, 0, '0, 1'b0, 1'b0);
    send_word(fmsr_pkg::OpRuleWr, 95, 0, 8'h00, 2, 16'h0001, 1'b0, 1'b0);
    send_word(fmsr_pkg::OpNameChar, 0, 0, "A", 0, '0, 1'b0, 1'b1);
    send_word(fmsr_pkg::OpNameChar, 0, 0, "b", 0, '0, 1'b1, 1'b1);
    send_word(fmsr_pkg::OpNameChar, 0, 0, 8'h00, 0, '0, 1'b0, 1'b1);
    send_word(fmsr_pkg::OpNameChar, 0, 0, 8'hFF, 0, '0, 1'b0, 1'b1);
    send_word(fmsr_pkg::OpNameChar, 0, 0, "x", 0, '0, 1'b1, 1'b0);
    // Table changed mid-name: disable rule 3 between characters.
    send_word(fmsr_pkg::OpNameChar, 0, 0, "a", 0, '0, 1'b0, 1'b1);
    send_word(fmsr_pkg::OpRuleWr, 3, 0, 8'h00, 0, 16'h0000, 1'b0, 1'b0);
    send_word(fmsr_pkg::OpNameChar, 0, 0, "b", 0, '0, 1'b1, 1'b1);
    // Full-length pattern, then an overlong length that saturates.
    send_rule(10, PatMax, 16'h8000);
    send_word(fmsr_pkg::OpRuleWr, 10, 0, 8'h00, 63, 16'h4000, 1'b0, 1'b0);

    settle();
    write_cfg(fmsr_pkg::CfgRuleCount, 16'd0);
    write_cfg(fmsr_pkg::CfgDefaultAspect, 16'hFFFF);
    random_phase(NumWords / 4);

    // No idling at all for a whole phase; rule limit at its top code.
    settle();
    idling_on = 1'b0;
    write_cfg(fmsr_pkg::CfgRuleCount, 16'd127);
    write_cfg(fmsr_pkg::CfgDefaultAspect, 16'h0000);
    random_phase(NumWords / 4);

    settle();
    idling_on = 1'b1;
    write_cfg(fmsr_pkg::CfgRuleCount, fmsr_pkg::CfgDataW'($urandom_range(1, 8)));
    write_cfg(fmsr_pkg::CfgDefaultAspect, fmsr_pkg::CfgDataW'($urandom));
    random_phase(NumWords / 4);

    settle();
    write_cfg(fmsr_pkg::CfgRuleCount, 16'd96);
    write_cfg(fmsr_pkg::CfgDefaultAspect, 16'h1000);
    random_phase(NumWords / 4);

    settle();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/fmsr_pkg.sv
rtl/fmsr_ram.sv
rtl/fmsr_ctrl.sv
rtl/fmsr_dpath.sv
rtl/first_match_substring_rule_table.sv
dv/fmsr_checker.sv
dv/tb_first_match_substring_rule_table.sv
